// ===== sv/mrss_pkg.sv =====
// ----------------------------------------------------------------------------
// Macro rail shot sequencer package
// Shared types and constants for the focus-stacking rail sequencer.
// ----------------------------------------------------------------------------
package mrss_pkg;

  // Fixed timing of the shutter click, in millisecond ticks.
  localparam int unsigned SHOOT_CLICK_MS = 100;

  // Widths of the configuration port and of the phase timer.
  localparam int unsigned CFG_DATA_W = 14;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned TIMER_W    = 14;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MOTOR_INTERVAL = 3'd0,
    CFG_SHOT_COUNT     = 3'd1,
    CFG_STEPS_PER_SHOT = 3'd2,
    CFG_REVERSE_DIR    = 3'd3,
    CFG_STABILIZE      = 3'd4,
    CFG_EXPOSE         = 3'd5,
    CFG_FOCUS          = 3'd6
  } cfg_idx_t;

  // Register values after reset.
  localparam logic [8:0]  RST_MOTOR_INTERVAL = 9'd50;
  localparam logic [7:0]  RST_SHOT_COUNT     = 8'd25;
  localparam logic [5:0]  RST_STEPS_PER_SHOT = 6'd4;
  localparam logic        RST_REVERSE_DIR    = 1'b0;
  localparam logic [13:0] RST_STABILIZE      = 14'd1000;
  localparam logic [13:0] RST_EXPOSE         = 14'd1000;
  localparam logic [12:0] RST_FOCUS          = 13'd0;

  // All configuration registers as one bundle.
  typedef struct packed {
    logic [8:0]  motor_interval_ms;
    logic [7:0]  shot_count;
    logic [5:0]  steps_per_shot;
    logic        reverse_direction;
    logic [13:0] stabilize_ms;
    logic [13:0] expose_ms;
    logic [12:0] focus_ms;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic step_pulse;
    logic step_backward;
    logic focus_line;
    logic shoot_line;
    logic busy_res;
    logic done_res;
  } res_t;

endpackage

// ===== sv/mrss_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Macro rail shot sequencer configuration registers
// Holds the seven sequencer settings written through the plain write port.
// ----------------------------------------------------------------------------
module mrss_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mrss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mrss_pkg::CFG_DATA_W-1:0] cfg_data,
  output mrss_pkg::cfg_t                  cfg
);

  mrss_pkg::cfg_t cfg_r;

  // Each register takes the low bits of the write data; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.motor_interval_ms <= mrss_pkg::RST_MOTOR_INTERVAL;
      cfg_r.shot_count        <= mrss_pkg::RST_SHOT_COUNT;
      cfg_r.steps_per_shot    <= mrss_pkg::RST_STEPS_PER_SHOT;
      cfg_r.reverse_direction <= mrss_pkg::RST_REVERSE_DIR;
      cfg_r.stabilize_ms      <= mrss_pkg::RST_STABILIZE;
      cfg_r.expose_ms         <= mrss_pkg::RST_EXPOSE;
      cfg_r.focus_ms          <= mrss_pkg::RST_FOCUS;
    end else if (cfg_we) begin
      case (mrss_pkg::cfg_idx_t'(cfg_index))
        mrss_pkg::CFG_MOTOR_INTERVAL: cfg_r.motor_interval_ms <= cfg_data[8:0];
        mrss_pkg::CFG_SHOT_COUNT:     cfg_r.shot_count        <= cfg_data[7:0];
        mrss_pkg::CFG_STEPS_PER_SHOT: cfg_r.steps_per_shot    <= cfg_data[5:0];
        mrss_pkg::CFG_REVERSE_DIR:    cfg_r.reverse_direction <= cfg_data[0];
        mrss_pkg::CFG_STABILIZE:      cfg_r.stabilize_ms      <= cfg_data[13:0];
        mrss_pkg::CFG_EXPOSE:         cfg_r.expose_ms         <= cfg_data[13:0];
        mrss_pkg::CFG_FOCUS:          cfg_r.focus_ms          <= cfg_data[12:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/mrss_step_core.sv =====
// ----------------------------------------------------------------------------
// Macro rail shot sequencer step core
// Phase state machine and counters; computes one tick per enabled cycle.
// ----------------------------------------------------------------------------
module mrss_step_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step_en,
  input  logic           start_req,
  input  logic           jog_forward,
  input  logic           jog_backward,
  input  mrss_pkg::cfg_t cfg,
  output mrss_pkg::res_t res
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_JOG,
    PH_STAB,
    PH_FOCUS,
    PH_SHOOT,
    PH_EXPOSE,
    PH_GLIDE,
    PH_RETURN
  } phase_t;

  // Where a phase change is headed before empty phases are skipped.
  typedef enum logic [2:0] {
    TG_STAB,
    TG_FOCUS,
    TG_SHOOT,
    TG_EXPOSE,
    TG_GLIDE,
    TG_SHOT_END,
    TG_RETURN
  } go_tgt_t;

  typedef struct packed {
    phase_t     ph;
    logic [7:0] shots;
    logic       clr_steps;
    logic       done;
  } go_res_t;

  localparam int unsigned TW = mrss_pkg::TIMER_W;

  phase_t        phase_r, phase_nxt;
  logic [TW-1:0] timer_r, timer_nxt;
  logic [7:0]    shots_r, shots_nxt;
  logic [5:0]    sis_r, sis_nxt;
  logic [13:0]   moved_r, moved_nxt;

  // Length of a phase in ticks; motor intervals never go below one tick.
  function automatic logic [TW-1:0] phase_len(phase_t ph, mrss_pkg::cfg_t c);
    logic [TW-1:0] ivl;
    ivl = (c.motor_interval_ms == '0) ? TW'(1) : TW'(c.motor_interval_ms);
    case (ph)
      PH_STAB:   phase_len = c.stabilize_ms;
      PH_FOCUS:  phase_len = TW'(c.focus_ms);
      PH_SHOOT:  phase_len = TW'(mrss_pkg::SHOOT_CLICK_MS);
      PH_EXPOSE: phase_len = c.expose_ms;
      default:   phase_len = ivl;
    endcase
  endfunction

  // Resolves a phase change, skipping empty phases in a fixed order.
  function automatic go_res_t do_go(go_tgt_t tgt, mrss_pkg::cfg_t c,
                                    logic [7:0] shots, logic [13:0] moved);
    go_res_t r;
    go_tgt_t t;
    logic    fin;
    r.ph        = PH_IDLE;
    r.shots     = shots;
    r.clr_steps = 1'b0;
    r.done      = 1'b0;
    t           = tgt;
    fin         = 1'b0;
    if (t == TG_EXPOSE) begin
      if (c.expose_ms != '0) begin
        r.ph = PH_EXPOSE;
        fin  = 1'b1;
      end else begin
        t = TG_GLIDE;
      end
    end
    if (!fin && t == TG_GLIDE) begin
      r.clr_steps = 1'b1;
      if (c.steps_per_shot != '0) begin
        r.ph = PH_GLIDE;
        fin  = 1'b1;
      end else begin
        t = TG_SHOT_END;
      end
    end
    if (!fin && t == TG_SHOT_END) begin
      r.shots = r.shots + 8'd1;
      t = (r.shots >= c.shot_count) ? TG_RETURN : TG_STAB;
    end
    if (!fin && t == TG_STAB) begin
      if (c.stabilize_ms != '0) begin
        r.ph = PH_STAB;
        fin  = 1'b1;
      end else begin
        t = TG_FOCUS;
      end
    end
    if (!fin && t == TG_FOCUS) begin
      if (c.focus_ms != '0) begin
        r.ph = PH_FOCUS;
        fin  = 1'b1;
      end else begin
        t = TG_SHOOT;
      end
    end
    if (!fin && t == TG_SHOOT) begin
      r.ph = PH_SHOOT;
      fin  = 1'b1;
    end
    if (!fin && t == TG_RETURN) begin
      if (moved != '0) begin
        r.ph = PH_RETURN;
      end else begin
        r.ph   = PH_IDLE;
        r.done = 1'b1;
      end
    end
    return r;
  endfunction

  // One tick: the idle decision first, then the work of the phase now active.
  always_comb begin
    go_res_t       g;
    logic          jog_back;
    logic [TW-1:0] tmr_inc;
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    shots_nxt = shots_r;
    sis_nxt   = sis_r;
    moved_nxt = moved_r;
    res       = '0;
    jog_back  = 1'b0;
    g         = '0;
    tmr_inc   = '0;

    if (phase_r == PH_IDLE) begin
      if (start_req) begin
        g = do_go((cfg.shot_count == '0) ? TG_RETURN : TG_STAB, cfg, 8'd0, 14'd0);
        phase_nxt    = g.ph;
        timer_nxt    = '0;
        shots_nxt    = g.shots;
        sis_nxt      = '0;
        moved_nxt    = '0;
        res.done_res = g.done;
      end else if (jog_forward || jog_backward) begin
        jog_back  = !jog_forward;
        phase_nxt = PH_JOG;
        timer_nxt = '0;
      end
    end

    if (phase_nxt != PH_IDLE) begin
      res.busy_res = 1'b1;
      if ((phase_nxt == PH_JOG || phase_nxt == PH_GLIDE || phase_nxt == PH_RETURN) &&
          timer_nxt == '0) begin
        res.step_pulse = 1'b1;
        if (phase_nxt == PH_JOG) begin
          res.step_backward = jog_back;
        end else if (phase_nxt == PH_GLIDE) begin
          res.step_backward = cfg.reverse_direction;
        end else begin
          res.step_backward = !cfg.reverse_direction;
        end
      end
      res.focus_line = (phase_nxt == PH_FOCUS || phase_nxt == PH_SHOOT);
      res.shoot_line = (phase_nxt == PH_SHOOT);
      tmr_inc   = timer_nxt + TW'(1);
      timer_nxt = tmr_inc;
      if (tmr_inc >= phase_len(phase_nxt, cfg)) begin
        case (phase_nxt)
          PH_JOG: begin
            phase_nxt = PH_IDLE;
            timer_nxt = '0;
          end
          PH_STAB, PH_FOCUS, PH_SHOOT, PH_EXPOSE: begin
            if (phase_nxt == PH_STAB) begin
              g = do_go(TG_FOCUS, cfg, shots_nxt, moved_nxt);
            end else if (phase_nxt == PH_FOCUS) begin
              g = do_go(TG_SHOOT, cfg, shots_nxt, moved_nxt);
            end else if (phase_nxt == PH_SHOOT) begin
              g = do_go(TG_EXPOSE, cfg, shots_nxt, moved_nxt);
            end else begin
              g = do_go(TG_GLIDE, cfg, shots_nxt, moved_nxt);
            end
            phase_nxt    = g.ph;
            timer_nxt    = '0;
            shots_nxt    = g.shots;
            res.done_res = g.done;
            if (g.clr_steps) begin
              sis_nxt = '0;
            end
          end
          PH_GLIDE: begin
            if (moved_nxt != 14'h3FFF) begin
              moved_nxt = moved_nxt + 14'd1;
            end
            sis_nxt = sis_nxt + 6'd1;
            if (sis_nxt >= cfg.steps_per_shot) begin
              g = do_go(TG_SHOT_END, cfg, shots_nxt, moved_nxt);
              phase_nxt    = g.ph;
              shots_nxt    = g.shots;
              res.done_res = g.done;
              if (g.clr_steps) begin
                sis_nxt = '0;
              end
            end
            timer_nxt = '0;
          end
          PH_RETURN: begin
            if (moved_nxt != '0) begin
              moved_nxt = moved_nxt - 14'd1;
            end
            if (moved_nxt == '0) begin
              phase_nxt    = PH_IDLE;
              res.done_res = 1'b1;
            end
            timer_nxt = '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // State advances once per tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      timer_r <= '0;
      shots_r <= '0;
      sis_r   <= '0;
      moved_r <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      shots_r <= shots_nxt;
      sis_r   <= sis_nxt;
      moved_r <= moved_nxt;
    end
  end

  // The timer is cleared whenever the sequencer rests.
  a_idle_timer_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> timer_r == '0)
    else $error("timer not clear while idle");

  // The return move only runs while steps remain to be undone.
  a_return_has_steps: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_RETURN |-> moved_r != '0)
    else $error("return phase with no steps left");

  // A jog interval never rests at timer zero, so it issues one step only.
  a_jog_single_step: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_JOG |-> timer_r != '0)
    else $error("jog interval at timer zero");

endmodule

// ===== sv/macro_rail_shot_sequencer.sv =====
// An accepted item is held in the input register; when it advances, its result item
// is captured in the result register. Throughput: one item per cycle unless the
// result channel stalls; the registers decouple the channels, one core tick per item.
// Reset: rst_n is synchronous and active low; it sets the sequencer idle, clears
// all counters, restores the register defaults and empties both registers.
// ----------------------------------------------------------------------------
// Macro rail shot sequencer
// Focus-stacking rail sequencer driven by one millisecond tick per input item.
// ----------------------------------------------------------------------------
module macro_rail_shot_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_start_req,
  input  logic                            in_jog_forward,
  input  logic                            in_jog_backward,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_step_pulse,
  output logic                            out_step_backward,
  output logic                            out_focus_line,
  output logic                            out_shoot_line,
  output logic                            out_busy_res,
  output logic                            out_done_res,
  input  logic                            cfg_we,
  input  logic [mrss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mrss_pkg::CFG_DATA_W-1:0] cfg_data
);

  mrss_pkg::cfg_t cfg;
  mrss_pkg::res_t res;
  mrss_pkg::res_t res_r;

  logic in_valid_r;
  logic start_r, fwd_r, bwd_r;
  logic out_valid_r;
  logic adv;

  mrss_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The held item moves on when the result register is empty or being drained.
  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;

  mrss_step_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (adv),
    .start_req    (start_r),
    .jog_forward  (fwd_r),
    .jog_backward (bwd_r),
    .cfg          (cfg),
    .res          (res)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      start_r <= in_start_req;
      fwd_r   <= in_jog_forward;
      bwd_r   <= in_jog_backward;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_step_pulse    = res_r.step_pulse;
  assign out_step_backward = res_r.step_backward;
  assign out_focus_line    = res_r.focus_line;
  assign out_shoot_line    = res_r.shoot_line;
  assign out_busy_res      = res_r.busy_res;
  assign out_done_res      = res_r.done_res;

  // The shutter only fires with focus held.
  a_shoot_needs_focus: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.shoot_line |-> res_r.focus_line)
    else $error("shoot line high without focus");

  // A step is only issued while a sequence or jog interval runs.
  a_step_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.step_pulse |-> res_r.busy_res)
    else $error("step pulse while not busy");

  // Every tick that advances leaves a result item behind.
  a_adv_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("advanced item produced no result");

endmodule

// ===== bench/macro_rail_shot_sequencer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Macro rail shot sequencer testbench
// Feeds millisecond tick items through a valid/stall channel with random gaps,
// stalls the result channel at random, and checks every result item field by
// field against a tick-accurate model of the rail phase machine. The run walks
// through several register settings, from empty sequences to long times.
// ----------------------------------------------------------------------------
module macro_rail_shot_sequencer_tb;

  localparam int unsigned RUN_LIMIT    = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned DATA_W       = mrss_pkg::CFG_DATA_W;

  // Phases of the rail machine as the model tracks them.
  typedef enum logic [2:0] {
    RAIL_IDLE, RAIL_JOG, RAIL_STAB, RAIL_FOCUS,
    RAIL_SHOOT, RAIL_EXPOSE, RAIL_GLIDE, RAIL_RETURN
  } rail_phase_t;

  // Destinations when a phase ends; some are decisions rather than phases.
  typedef enum logic [2:0] {
    TO_STAB, TO_FOCUS, TO_SHOOT, TO_EXPOSE, TO_GLIDE, TO_SHOT_END, TO_RETURN
  } rail_target_t;

  // One tick item on the input channel.
  typedef struct packed {
    logic start_req;
    logic jog_forward;
    logic jog_backward;
  } tick_t;

  logic                            clk             = 1'b0;
  logic                            rst_n           = 1'b0;
  logic                            in_valid        = 1'b0;
  logic                            in_stall;
  logic                            in_start_req    = 1'b0;
  logic                            in_jog_forward  = 1'b0;
  logic                            in_jog_backward = 1'b0;
  logic                            out_valid;
  logic                            out_stall       = 1'b0;
  logic                            out_step_pulse;
  logic                            out_step_backward;
  logic                            out_focus_line;
  logic                            out_shoot_line;
  logic                            out_busy_res;
  logic                            out_done_res;
  logic                            cfg_we          = 1'b0;
  logic [mrss_pkg::CFG_IDX_W-1:0]  cfg_index       = '0;
  logic [mrss_pkg::CFG_DATA_W-1:0] cfg_data        = '0;

  macro_rail_shot_sequencer u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_start_req      (in_start_req),
    .in_jog_forward    (in_jog_forward),
    .in_jog_backward   (in_jog_backward),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_step_pulse    (out_step_pulse),
    .out_step_backward (out_step_backward),
    .out_focus_line    (out_focus_line),
    .out_shoot_line    (out_shoot_line),
    .out_busy_res      (out_busy_res),
    .out_done_res      (out_done_res),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #5 clk = ~clk;

  // Model copy of the registers and of the sequencer state.
  mrss_pkg::cfg_t rail_cfg;
  rail_phase_t    rail_phase;
  logic [13:0]    phase_ticks;
  logic [7:0]     shots_taken;
  logic [5:0]     shot_steps;
  logic [13:0]    steps_out;

  tick_t          ticks_pending[$];
  mrss_pkg::res_t results_due[$];

  // Field names of res_t, indexed by bit position.
  string res_field [0:5] = '{"done_res", "busy_res", "shoot_line", "focus_line",
                             "step_backward", "step_pulse"};

  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;

  // Input side state.
  int unsigned in_gap  = 0;
  logic        in_calm = 1'b0;
  tick_t       in_next;

  // Result side state.
  int unsigned    out_hold = 0;
  logic           out_calm = 1'b0;
  int unsigned    hold_draw;
  mrss_pkg::res_t seen_res;
  mrss_pkg::res_t want_res;

  function automatic tick_t tick_of(logic start, logic fwd, logic bwd);
    tick_t t;
    t.start_req    = start;
    t.jog_forward  = fwd;
    t.jog_backward = bwd;
    return t;
  endfunction

  // Appends one tick item to the pending list.
  task automatic queue_tick(logic start, logic fwd, logic bwd);
    ticks_pending = {ticks_pending, tick_of(start, fwd, bwd)};
  endtask

  // Length of a phase in ticks under the current registers.
  function automatic int unsigned phase_length(rail_phase_t ph);
    case (ph)
      RAIL_STAB:   return 32'(rail_cfg.stabilize_ms);
      RAIL_FOCUS:  return 32'(rail_cfg.focus_ms);
      RAIL_SHOOT:  return (mrss_pkg::SHOOT_CLICK_MS < 1) ? 1 : mrss_pkg::SHOOT_CLICK_MS;
      RAIL_EXPOSE: return 32'(rail_cfg.expose_ms);
      default:     return (rail_cfg.motor_interval_ms == 0) ? 1 :
                          32'(rail_cfg.motor_interval_ms);
    endcase
  endfunction

  function automatic void enter_phase(rail_phase_t ph);
    rail_phase  = ph;
    phase_ticks = '0;
  endfunction

  // Walks toward a target, skipping empty phases; returns 1 when the sequence ends.
  function automatic logic advance_to(rail_target_t target);
    rail_target_t t;
    t = target;
    repeat (16) begin
      case (t)
        TO_STAB: begin
          if (phase_length(RAIL_STAB) != 0) begin
            enter_phase(RAIL_STAB);
            return 1'b0;
          end
          t = TO_FOCUS;
        end
        TO_FOCUS: begin
          if (phase_length(RAIL_FOCUS) != 0) begin
            enter_phase(RAIL_FOCUS);
            return 1'b0;
          end
          t = TO_SHOOT;
        end
        TO_SHOOT: begin
          enter_phase(RAIL_SHOOT);
          return 1'b0;
        end
        TO_EXPOSE: begin
          if (phase_length(RAIL_EXPOSE) != 0) begin
            enter_phase(RAIL_EXPOSE);
            return 1'b0;
          end
          t = TO_GLIDE;
        end
        TO_GLIDE: begin
          shot_steps = '0;
          if (rail_cfg.steps_per_shot != 0) begin
            enter_phase(RAIL_GLIDE);
            return 1'b0;
          end
          t = TO_SHOT_END;
        end
        TO_SHOT_END: begin
          shots_taken = shots_taken + 8'd1;
          t = (shots_taken >= rail_cfg.shot_count) ? TO_RETURN : TO_STAB;
        end
        default: begin
          if (steps_out != 0) begin
            enter_phase(RAIL_RETURN);
            return 1'b0;
          end
          enter_phase(RAIL_IDLE);
          return 1'b1;
        end
      endcase
    end
    enter_phase(RAIL_IDLE);
    return 1'b0;
  endfunction

  // One millisecond tick of the rail machine; returns the result item it causes.
  function automatic mrss_pkg::res_t rail_tick(tick_t tk);
    mrss_pkg::res_t r;
    logic           jog_back;
    rail_phase_t    ph;
    r        = '0;
    jog_back = 1'b0;

    // While idle, a start request wins over jogging, and forward over backward.
    if (rail_phase == RAIL_IDLE) begin
      if (tk.start_req) begin
        steps_out   = '0;
        shots_taken = '0;
        shot_steps  = '0;
        r.done_res  = advance_to((rail_cfg.shot_count == 0) ? TO_RETURN : TO_STAB);
      end else if (tk.jog_forward || tk.jog_backward) begin
        jog_back = !tk.jog_forward;
        enter_phase(RAIL_JOG);
      end
    end

    if (rail_phase != RAIL_IDLE) begin
      ph         = rail_phase;
      r.busy_res = 1'b1;
      // A step pulse opens every motor interval.
      if (phase_ticks == 0 && (ph == RAIL_JOG || ph == RAIL_GLIDE || ph == RAIL_RETURN)) begin
        r.step_pulse = 1'b1;
        case (ph)
          RAIL_JOG:   r.step_backward = jog_back;
          RAIL_GLIDE: r.step_backward = rail_cfg.reverse_direction;
          default:    r.step_backward = !rail_cfg.reverse_direction;
        endcase
      end
      r.focus_line = (ph == RAIL_FOCUS || ph == RAIL_SHOOT);
      r.shoot_line = (ph == RAIL_SHOOT);
      phase_ticks  = phase_ticks + 14'd1;

      // The phase ends once its elapsed time reaches the current length.
      if (phase_ticks >= phase_length(ph)) begin
        case (ph)
          RAIL_JOG:    enter_phase(RAIL_IDLE);
          RAIL_STAB:   r.done_res = advance_to(TO_FOCUS);
          RAIL_FOCUS:  r.done_res = advance_to(TO_SHOOT);
          RAIL_SHOOT:  r.done_res = advance_to(TO_EXPOSE);
          RAIL_EXPOSE: r.done_res = advance_to(TO_GLIDE);
          RAIL_GLIDE: begin
            if (steps_out < 14'h3FFF) steps_out = steps_out + 14'd1;
            shot_steps = shot_steps + 6'd1;
            if (shot_steps >= rail_cfg.steps_per_shot) begin
              r.done_res = advance_to(TO_SHOT_END);
            end else begin
              phase_ticks = '0;
            end
          end
          default: begin
            if (steps_out != 0) steps_out = steps_out - 14'd1;
            if (steps_out == 0) begin
              enter_phase(RAIL_IDLE);
              r.done_res = 1'b1;
            end else begin
              phase_ticks = '0;
            end
          end
        endcase
      end
    end
    return r;
  endfunction

  // Writes one register and mirrors it into the model.
  task automatic write_reg(mrss_pkg::cfg_idx_t idx, logic [mrss_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      mrss_pkg::CFG_MOTOR_INTERVAL: rail_cfg.motor_interval_ms = val[8:0];
      mrss_pkg::CFG_SHOT_COUNT:     rail_cfg.shot_count        = val[7:0];
      mrss_pkg::CFG_STEPS_PER_SHOT: rail_cfg.steps_per_shot    = val[5:0];
      mrss_pkg::CFG_REVERSE_DIR:    rail_cfg.reverse_direction = val[0];
      mrss_pkg::CFG_STABILIZE:      rail_cfg.stabilize_ms      = val[13:0];
      mrss_pkg::CFG_EXPOSE:         rail_cfg.expose_ms         = val[13:0];
      mrss_pkg::CFG_FOCUS:          rail_cfg.focus_ms          = val[12:0];
      default: ;
    endcase
  endtask

  // Waits until every item has come back, then writes all registers.
  task automatic configure(int unsigned interval, int unsigned shots, int unsigned steps,
                           int unsigned reverse, int unsigned stab, int unsigned expose,
                           int unsigned focus);
    while (ticks_pending.size() != 0 || in_valid || results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(mrss_pkg::CFG_MOTOR_INTERVAL, DATA_W'(interval));
    write_reg(mrss_pkg::CFG_SHOT_COUNT, DATA_W'(shots));
    write_reg(mrss_pkg::CFG_STEPS_PER_SHOT, DATA_W'(steps));
    write_reg(mrss_pkg::CFG_REVERSE_DIR, DATA_W'(reverse));
    write_reg(mrss_pkg::CFG_STABILIZE, DATA_W'(stab));
    write_reg(mrss_pkg::CFG_EXPOSE, DATA_W'(expose));
    write_reg(mrss_pkg::CFG_FOCUS, DATA_W'(focus));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Queues random ticks; start_odds sets how often a start request shows up.
  task automatic random_ticks(int unsigned count, int unsigned start_odds);
    repeat (count) begin
      queue_tick($urandom_range(start_odds - 1, 0) == 0,
                 $urandom_range(3, 0) == 0,
                 $urandom_range(2, 0) == 0);
    end
  endtask

  // Input driver: predicts each accepted item, then offers the next after its gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        results_due = {results_due,
                       rail_tick(tick_of(in_start_req, in_jog_forward, in_jog_backward))};
      end
      if (!(in_valid && in_stall)) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (ticks_pending.size() != 0) begin
          in_next = ticks_pending.pop_front();
          in_valid        <= 1'b1;
          in_start_req    <= in_next.start_req;
          in_jog_forward  <= in_next.jog_forward;
          in_jog_backward <= in_next.jog_backward;
          if ($urandom_range(39, 0) == 0) in_calm <= !in_calm;
          in_gap <= in_calm ? 0 : $urandom_range(11, 0);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each accepted item, then stalls for a drawn number of cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold  <= 0;
    end else if (out_valid && !out_stall) begin
      seen_res = {out_step_pulse, out_step_backward, out_focus_line,
                  out_shoot_line, out_busy_res, out_done_res};
      if (results_due.size() == 0) begin
        $error("result item arrived with no expected item waiting");
        fail_count++;
      end else begin
        want_res = results_due.pop_front();
        for (int b = 0; b < 6; b++) begin
          if (seen_res[b] !== want_res[b]) begin
            $error("%s: expected %0b, actual %0b", res_field[b], want_res[b], seen_res[b]);
            fail_count++;
          end
        end
      end
      if ($urandom_range(39, 0) == 0) out_calm <= !out_calm;
      hold_draw = out_calm ? 0 : $urandom_range(11, 0);
      out_hold  <= hold_draw;
      out_stall <= (hold_draw != 0);
    end else if (out_hold != 0) begin
      out_hold  <= out_hold - 1;
      out_stall <= (out_hold > 1);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rail_cfg.motor_interval_ms = mrss_pkg::RST_MOTOR_INTERVAL;
    rail_cfg.shot_count        = mrss_pkg::RST_SHOT_COUNT;
    rail_cfg.steps_per_shot    = mrss_pkg::RST_STEPS_PER_SHOT;
    rail_cfg.reverse_direction = mrss_pkg::RST_REVERSE_DIR;
    rail_cfg.stabilize_ms      = mrss_pkg::RST_STABILIZE;
    rail_cfg.expose_ms         = mrss_pkg::RST_EXPOSE;
    rail_cfg.focus_ms          = mrss_pkg::RST_FOCUS;
    rail_phase  = RAIL_IDLE;
    phase_ticks = '0;
    shots_taken = '0;
    shot_steps  = '0;
    steps_out   = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Zero interval acts as one tick; zero shot count ends on the start tick.
    configure(0, 0, 2, 1, 0, 0, 0);
    queue_tick(1'b0, 1'b0, 1'b0);
    queue_tick(1'b1, 1'b1, 1'b1);
    queue_tick(1'b1, 1'b0, 1'b0);
    queue_tick(1'b0, 1'b1, 1'b1);
    queue_tick(1'b0, 1'b0, 1'b1);
    queue_tick(1'b0, 1'b1, 1'b0);
    queue_tick(1'b0, 1'b0, 1'b0);

    // Two-tick jogs: inputs during a jog interval are ignored.
    configure(2, 0, 1, 0, 0, 0, 0);
    queue_tick(1'b0, 1'b1, 1'b0);
    queue_tick(1'b0, 1'b0, 1'b1);
    queue_tick(1'b0, 1'b0, 1'b1);
    queue_tick(1'b1, 1'b0, 1'b0);
    queue_tick(1'b1, 1'b0, 1'b0);
    queue_tick(1'b0, 1'b0, 1'b0);

    // Zero steps per shot: the return is empty and done comes as the shot ends.
    configure(1, 1, 0, 0, 0, 0, 0);
    random_ticks(150, 3);

    configure(0, 2, 3, 1, 2, 3, 2);
    random_ticks(180, 4);

    configure(3, 3, 2, 0, 1, 0, 4);
    random_ticks(200, 4);

    // A large step count per shot.
    configure(1, 2, 50, 1, 0, 0, 0);
    random_ticks(150, 4);

    // A long motor interval.
    configure(500, 1, 1, 0, 0, 0, 0);
    random_ticks(150, 8);

    // Large values in every register; later settings cut the long waits short.
    configure(500, 250, 50, 1, 10000, 10000, 5000);
    random_ticks(120, 2);

    repeat (4) begin
      configure($urandom_range(4, 0), $urandom_range(3, 0), $urandom_range(4, 0),
                $urandom_range(1, 0), $urandom_range(6, 0), $urandom_range(6, 0),
                $urandom_range(6, 0));
      random_ticks(100, $urandom_range(6, 3));
    end

    while (ticks_pending.size() != 0 || in_valid || results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
